@@ hdl/ttg_pkg.sv @@
// Shared types and constants of the triangle tangent generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ttg_pkg;

   localparam int REF_COORD_W  = 16;
   localparam int THRESH_W     = 20;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd17;
   localparam int EDGE_W       = 17;
   localparam int PROD_W       = 35;
   localparam int MUL_W        = 31;
   localparam int SUM_W        = 62;
   localparam int MAG_W        = 30;
   localparam int SHIFT_W      = 3;
   localparam int LEN_W        = 31;
   localparam int FRAC_SHIFT   = 15;
   localparam int DIV_W        = 16;
   localparam int NUM_W        = MAG_W + DIV_W;
   localparam int REM_W        = LEN_W + 2;
   localparam int OUT_W        = 16;
   localparam int N_AXES       = 3;
   localparam int AXIS_W       = 2;
   localparam int N_EDGE_PROD  = 8;
   localparam int N_SQUARES    = 3;
   localparam int SQRT_STEPS   = 31;
   localparam int CNT_W        = 5;
   localparam logic [OUT_W-1:0] UNIT_ONE = 16'd16384;
   localparam logic [SUM_W-1:0] SQRT_TOP = SUM_W'(1) << (SUM_W - 2);

   localparam logic [1:0] SLOT_FIRST  = 2'd0;
   localparam logic [1:0] SLOT_SECOND = 2'd1;
   localparam logic [1:0] SLOT_THIRD  = 2'd2;

   typedef enum logic [3:0] {
      M_DET_A,
      M_DET_B,
      M_TX_A,
      M_TX_B,
      M_TY_A,
      M_TY_B,
      M_TZ_A,
      M_TZ_B,
      M_SQ_0,
      M_SQ_1,
      M_SQ_2
   } mul_code_type;

   typedef struct packed {
      logic              load_v0;
      logic              load_v1;
      logic              load_v2;
      logic              mul_en;
      mul_code_type      mul_code;
      logic              acc_en;
      mul_code_type      acc_code;
      logic              mag_en;
      logic              norm_en;
      logic              sqrt_init;
      logic              sqrt_en;
      logic              div_init;
      logic              div_en;
      logic              div_write;
      logic [AXIS_W-1:0] div_sel;
      logic              out_load;
   } ttg_cmd_type;

   typedef struct packed {
      logic fallback;
      logic out_free;
   } ttg_stat_type;

endpackage

@@ hdl/ttg_if.sv @@
// Valid/ready channel interfaces: vertex requests and tangent responses.
// Depends on ttg_pkg for the response field widths.
`timescale 1ns / 1ps

interface ttg_req_if #(parameter int COORD_WIDTH = 16) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] pos_x;
   logic signed [COORD_WIDTH-1:0] pos_y;
   logic signed [COORD_WIDTH-1:0] pos_z;
   logic signed [COORD_WIDTH-1:0] tex_u;
   logic signed [COORD_WIDTH-1:0] tex_v;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttg_rsp_if import ttg_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] tangent_x;
   logic signed [OUT_W-1:0] tangent_y;
   logic signed [OUT_W-1:0] tangent_z;
   logic                    degenerate;

   modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
   modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

@@ hdl/ttg_ctrl.sv @@
// Sequencer of the tangent generator: vertex count, step counters, commands.
// Depends on ttg_pkg for the command and status structs.
`timescale 1ns / 1ps

module ttg_ctrl import ttg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ttg_stat_type stat,
   output ttg_cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_MUL  = 10'b00_0000_0010,
      S_MAG  = 10'b00_0000_0100,
      S_NORM = 10'b00_0000_1000,
      S_SQR  = 10'b00_0001_0000,
      S_SQRT = 10'b00_0010_0000,
      S_DIVI = 10'b00_0100_0000,
      S_DIV  = 10'b00_1000_0000,
      S_DIVW = 10'b01_0000_0000,
      S_OUT  = 10'b10_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AXIS_W-1:0] comp_ff, comp_in;
   logic [1:0]        slot_ff, slot_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      comp_in   = comp_ff;
      slot_in   = slot_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (slot_ff)
                  SLOT_FIRST: begin
                     cmd.load_v0 = 1'b1;
                     slot_in     = SLOT_SECOND;
                  end
                  SLOT_SECOND: begin
                     cmd.load_v1 = 1'b1;
                     slot_in     = SLOT_THIRD;
                  end
                  SLOT_THIRD: begin
                     cmd.load_v2 = 1'b1;
                     slot_in     = SLOT_FIRST;
                     cnt_in      = '0;
                     state_in    = S_MUL;
                  end
                  default: slot_in = SLOT_FIRST;
               endcase
            end
         end
         S_MUL: begin
            cmd.mul_en   = cnt_ff < CNT_W'(N_EDGE_PROD);
            cmd.mul_code = mul_code_type'(cnt_ff[3:0]);
            cmd.acc_en   = cnt_ff != '0;
            cmd.acc_code = mul_code_type'(cnt_ff[3:0] - 4'd1);
            if (cnt_ff == CNT_W'(N_EDGE_PROD)) begin
               cnt_in   = '0;
               state_in = S_MAG;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_MAG: begin
            cmd.mag_en = 1'b1;
            state_in   = S_NORM;
         end
         S_NORM: begin
            cmd.norm_en = 1'b1;
            cnt_in      = '0;
            state_in    = stat.fallback ? S_OUT : S_SQR;
         end
         S_SQR: begin
            cmd.mul_en   = cnt_ff < CNT_W'(N_SQUARES);
            cmd.mul_code = mul_code_type'(4'(M_SQ_0) + cnt_ff[3:0]);
            cmd.acc_en   = cnt_ff != '0;
            cmd.acc_code = mul_code_type'(4'(M_SQ_0) + cnt_ff[3:0] - 4'd1);
            if (cnt_ff == CNT_W'(N_SQUARES)) begin
               cnt_in   = '0;
               state_in = S_SQRT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_SQRT: begin
            cmd.sqrt_init = cnt_ff == '0;
            cmd.sqrt_en   = cnt_ff != '0;
            if (cnt_ff == CNT_W'(SQRT_STEPS)) begin
               cnt_in   = '0;
               comp_in  = '0;
               state_in = S_DIVI;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            cmd.div_sel  = comp_ff;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               state_in = S_DIVW;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DIVW: begin
            cmd.div_write = 1'b1;
            cmd.div_sel   = comp_ff;
            if (comp_ff == AXIS_W'(N_AXES - 1)) begin
               state_in = S_OUT;
            end else begin
               comp_in  = comp_ff + AXIS_W'(1);
               state_in = S_DIVI;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         comp_ff  <= '0;
         slot_ff  <= SLOT_FIRST;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

@@ hdl/ttg_dpath.sv @@
// Datapath: vertex store, edges, shared multiplier, bit-serial square root,
// restoring divider and output register. Depends on ttg_pkg.
`timescale 1ns / 1ps

module ttg_dpath import ttg_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ttg_cmd_type                   cmd,
   output ttg_stat_type                  stat,
   input  logic signed [COORD_WIDTH-1:0] in_pos [N_AXES],
   input  logic signed [COORD_WIDTH-1:0] in_tex [2],
   input  logic                          csr_we,
   input  logic [THRESH_W-1:0]           csr_wdata,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [OUT_W-1:0]       rsp_tan [N_AXES],
   output logic                          rsp_degenerate
);

   localparam int DIFF_W     = COORD_WIDTH + 1;
   localparam int EDGE_SHIFT = (COORD_WIDTH > REF_COORD_W) ? COORD_WIDTH - REF_COORD_W : 0;

   function automatic logic signed [EDGE_W-1:0] edge_diff(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      logic signed [DIFF_W-1:0] d;
      d = DIFF_W'(a) - DIFF_W'(b);
      return EDGE_W'(d >>> EDGE_SHIFT);
   endfunction

   logic signed [COORD_WIDTH-1:0] v0_pos_ff [N_AXES];
   logic signed [COORD_WIDTH-1:0] v1_pos_ff [N_AXES];
   logic signed [COORD_WIDTH-1:0] v0_tex_ff [2];
   logic signed [COORD_WIDTH-1:0] v1_tex_ff [2];
   logic signed [EDGE_W-1:0]      e1_ff [N_AXES];
   logic signed [EDGE_W-1:0]      e2_ff [N_AXES];
   logic signed [EDGE_W-1:0]      du1_ff, dv1_ff, du2_ff, dv2_ff;

   logic signed [MUL_W-1:0]       mul_a, mul_b;
   logic signed [SUM_W-1:0]       prod_ff;
   logic signed [PROD_W-1:0]      prod_lo;
   logic signed [PROD_W-1:0]      acc_ff, det_ff;
   logic signed [PROD_W-1:0]      t_ff [N_AXES];
   logic [SUM_W-1:0]              sum_ff;

   logic                          det_neg;
   logic [PROD_W-1:0]             det_abs;
   logic [PROD_W-1:0]             tmag [N_AXES];
   logic [PROD_W-1:0]             mag_ff [N_AXES];
   logic [N_AXES-1:0]             neg_ff;
   logic                          det_small_ff;
   logic [PROD_W-1:0]             mag_or;
   logic [SHIFT_W-1:0]            sh;
   logic [MAG_W-1:0]              nmag_ff [N_AXES];
   logic                          fallback_in, fb_ff;

   logic [SUM_W-1:0]              x_ff, res_ff, bit_ff, rb;
   logic [LEN_W-1:0]              len;
   logic [LEN_W:0]                dvs;
   logic [NUM_W-1:0]              num;
   logic [REM_W-1:0]              rem_ff, trial;
   logic [DIV_W-1:0]              num_ff, q_ff, qc;
   logic signed [OUT_W-1:0]       tan_ff [N_AXES];

   logic [THRESH_W-1:0]           thr_ff;
   logic                          rsp_valid_ff;
   logic signed [OUT_W-1:0]       rsp_tan_ff [N_AXES];
   logic                          rsp_deg_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_code)
         M_DET_A: begin mul_a = MUL_W'(du1_ff); mul_b = MUL_W'(dv2_ff); end
         M_DET_B: begin mul_a = MUL_W'(du2_ff); mul_b = MUL_W'(dv1_ff); end
         M_TX_A:  begin mul_a = MUL_W'(dv2_ff); mul_b = MUL_W'(e1_ff[0]); end
         M_TX_B:  begin mul_a = MUL_W'(dv1_ff); mul_b = MUL_W'(e2_ff[0]); end
         M_TY_A:  begin mul_a = MUL_W'(dv2_ff); mul_b = MUL_W'(e1_ff[1]); end
         M_TY_B:  begin mul_a = MUL_W'(dv1_ff); mul_b = MUL_W'(e2_ff[1]); end
         M_TZ_A:  begin mul_a = MUL_W'(dv2_ff); mul_b = MUL_W'(e1_ff[2]); end
         M_TZ_B:  begin mul_a = MUL_W'(dv1_ff); mul_b = MUL_W'(e2_ff[2]); end
         M_SQ_0:  begin mul_a = {1'b0, nmag_ff[0]}; mul_b = {1'b0, nmag_ff[0]}; end
         M_SQ_1:  begin mul_a = {1'b0, nmag_ff[1]}; mul_b = {1'b0, nmag_ff[1]}; end
         M_SQ_2:  begin mul_a = {1'b0, nmag_ff[2]}; mul_b = {1'b0, nmag_ff[2]}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_lo = prod_ff[PROD_W-1:0];

   // magnitudes, sign of det folded into the component signs
   always_comb begin
      det_neg = det_ff[PROD_W-1];
      det_abs = det_neg ? PROD_W'(-det_ff) : PROD_W'(det_ff);
      for (int i = 0; i < N_AXES; i++) begin
         tmag[i] = t_ff[i][PROD_W-1] ? PROD_W'(-t_ff[i]) : PROD_W'(t_ff[i]);
      end
   end

   // normalizing shift from the highest set bit of the largest magnitude
   always_comb begin
      mag_or = mag_ff[0] | mag_ff[1] | mag_ff[2];
      sh     = '0;
      for (int k = MAG_W; k < PROD_W; k++) begin
         if (mag_or[k]) sh = SHIFT_W'(k - MAG_W + 1);
      end
      fallback_in = det_small_ff || (mag_or == '0);
   end

   assign rb    = res_ff + bit_ff;
   assign len   = res_ff[LEN_W-1:0];
   assign dvs   = {len, 1'b0};
   assign num   = NUM_W'({nmag_ff[cmd.div_sel], {FRAC_SHIFT{1'b0}}}) + NUM_W'(len);
   assign trial = {rem_ff[REM_W-2:0], num_ff[DIV_W-1]};
   assign qc    = (q_ff > UNIT_ONE) ? UNIT_ONE : q_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_v0) begin
         v0_pos_ff <= in_pos;
         v0_tex_ff <= in_tex;
      end
      if (cmd.load_v1) begin
         v1_pos_ff <= in_pos;
         v1_tex_ff <= in_tex;
      end
      if (cmd.load_v2) begin
         for (int i = 0; i < N_AXES; i++) begin
            e1_ff[i] <= edge_diff(v1_pos_ff[i], v0_pos_ff[i]);
            e2_ff[i] <= edge_diff(in_pos[i], v0_pos_ff[i]);
         end
         du1_ff <= edge_diff(v1_tex_ff[0], v0_tex_ff[0]);
         dv1_ff <= edge_diff(v1_tex_ff[1], v0_tex_ff[1]);
         du2_ff <= edge_diff(in_tex[0], v0_tex_ff[0]);
         dv2_ff <= edge_diff(in_tex[1], v0_tex_ff[1]);
      end
      if (cmd.mul_en) prod_ff <= mul_a * mul_b;
      if (cmd.acc_en) begin
         unique case (cmd.acc_code)
            M_DET_A, M_TX_A, M_TY_A, M_TZ_A: acc_ff <= prod_lo;
            M_DET_B:          det_ff  <= acc_ff - prod_lo;
            M_TX_B:           t_ff[0] <= acc_ff - prod_lo;
            M_TY_B:           t_ff[1] <= acc_ff - prod_lo;
            M_TZ_B:           t_ff[2] <= acc_ff - prod_lo;
            M_SQ_0:           sum_ff  <= $unsigned(prod_ff);
            M_SQ_1, M_SQ_2:   sum_ff  <= sum_ff + $unsigned(prod_ff);
            default:          acc_ff  <= acc_ff;
         endcase
      end
      if (cmd.mag_en) begin
         for (int i = 0; i < N_AXES; i++) begin
            mag_ff[i] <= tmag[i];
            neg_ff[i] <= t_ff[i][PROD_W-1] ^ det_neg;
         end
         det_small_ff <= det_abs < PROD_W'(thr_ff);
      end
      if (cmd.norm_en) begin
         for (int i = 0; i < N_AXES; i++) begin
            nmag_ff[i] <= MAG_W'(mag_ff[i] >> sh);
         end
         fb_ff <= fallback_in;
      end
      if (cmd.sqrt_init) begin
         x_ff   <= sum_ff;
         res_ff <= '0;
         bit_ff <= SQRT_TOP;
      end else if (cmd.sqrt_en) begin
         if (x_ff >= rb) begin
            x_ff   <= x_ff - rb;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         rem_ff <= REM_W'(num[NUM_W-1:DIV_W]);
         num_ff <= num[DIV_W-1:0];
         q_ff   <= '0;
      end else if (cmd.div_en) begin
         if (trial >= REM_W'(dvs)) begin
            rem_ff <= trial - REM_W'(dvs);
            q_ff   <= {q_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff   <= {q_ff[DIV_W-2:0], 1'b0};
         end
         num_ff <= num_ff << 1;
      end
      if (cmd.div_write) begin
         tan_ff[cmd.div_sel] <= neg_ff[cmd.div_sel] ? -qc : qc;
      end
      if (cmd.out_load) begin
         if (fb_ff) begin
            rsp_tan_ff[0] <= UNIT_ONE;
            rsp_tan_ff[1] <= '0;
            rsp_tan_ff[2] <= '0;
         end else begin
            rsp_tan_ff <= tan_ff;
         end
         rsp_deg_ff <= fb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) thr_ff <= csr_wdata;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.fallback  = fallback_in;
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tan        = rsp_tan_ff;
   assign rsp_degenerate = rsp_deg_ff;

endmodule

@@ hdl/triangle_tangent_generator.sv @@
// Top level: joins the sequencer and the datapath to the channel interfaces.
// Depends on ttg_pkg, ttg_if, ttg_ctrl and ttg_dpath.
//
//   channel  dir  handshake       content
//   req_ch   in   valid / ready   one vertex: pos_x, pos_y, pos_z, tex_u, tex_v
//   rsp_ch   out  valid / ready   one triangle: tangent_x/y/z (Q1.14), degenerate
//   csr      in   csr_we          degenerate_threshold, 20 bits
//
// The first and second vertex of a triangle are stored as they come. The third starts
// the computation, and no vertex is taken until its result is loaded: a one-bit-a-cycle
// square root, then three restoring divides on one divider; the fallback skips both.
// Synchronous reset clears the vertex count and sets the threshold to 17.
// A waiting result does not stop vertex intake; a finished triangle holds in the
// last step until the output register is free.
`timescale 1ns / 1ps

module triangle_tangent_generator import ttg_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   ttg_req_if.sink             req_ch,
   ttg_rsp_if.source           rsp_ch,
   input  logic                csr_we,
   input  logic [THRESH_W-1:0] csr_wdata
);

   ttg_cmd_type                   cmd;
   ttg_stat_type                  stat;
   logic signed [COORD_WIDTH-1:0] in_pos [N_AXES];
   logic signed [COORD_WIDTH-1:0] in_tex [2];
   logic signed [OUT_W-1:0]       rsp_tan [N_AXES];

   assign in_pos[0] = req_ch.pos_x;
   assign in_pos[1] = req_ch.pos_y;
   assign in_pos[2] = req_ch.pos_z;
   assign in_tex[0] = req_ch.tex_u;
   assign in_tex[1] = req_ch.tex_v;

   ttg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttg_dpath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_pos         (in_pos),
      .in_tex         (in_tex),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_tan        (rsp_tan),
      .rsp_degenerate (rsp_ch.degenerate)
   );

   assign rsp_ch.tangent_x = rsp_tan[0];
   assign rsp_ch.tangent_y = rsp_tan[1];
   assign rsp_ch.tangent_z = rsp_tan[2];

`ifndef ASSERT_OFF
   a_busy_after_third : assert property (@(posedge clock) disable iff (reset)
      cmd.load_v2 |=> !req_ch.ready)
      else $error("item taken while a triangle is in progress");

   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("output register overwritten before it was taken");

   a_fallback_value : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.degenerate) |->
         (rsp_ch.tangent_x == $signed(UNIT_ONE) && rsp_ch.tangent_y == '0 &&
          rsp_ch.tangent_z == '0))
      else $error("degenerate item without the fallback tangent");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.degenerate) |->
         (rsp_ch.tangent_x <= $signed(UNIT_ONE) && rsp_ch.tangent_x >= -$signed(UNIT_ONE) &&
          rsp_ch.tangent_y <= $signed(UNIT_ONE) && rsp_ch.tangent_y >= -$signed(UNIT_ONE) &&
          rsp_ch.tangent_z <= $signed(UNIT_ONE) && rsp_ch.tangent_z >= -$signed(UNIT_ONE)))
      else $error("tangent component outside the unit range");
`endif

endmodule
